// File: rtl/rrsa_pkg.sv
package rrsa_pkg;

   localparam int ROW_WIDTH_W = 13;
   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 13'd1920;

   localparam int PIX_W = 8;
   localparam int SUM_W = 16;
   localparam int COUNT_W = 5;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

   // width / 10 as (width * 6554) >> 16, exact for every 13-bit width
   localparam int STEP_RECIP_W = 13;
   localparam logic [STEP_RECIP_W-1:0] STEP_RECIP = 13'd6554;
   localparam int STEP_SHIFT = 16;

   localparam int NUM_CHAN = 3;
   localparam int DIV_STEPS = NUM_CHAN * SUM_W;
   localparam int DIV_STEP_W = $clog2(DIV_STEPS);
   localparam int CHAN_BIT_W = $clog2(SUM_W);

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [SUM_W-1:0] sum_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef struct packed {
      sum_type red;
      sum_type green;
      sum_type blue;
   } rgb_sum_type;

   typedef struct packed {
      pix_type red;
      pix_type green;
      pix_type blue;
   } rgb_pix_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [1:0] {
      ST_RUN = 2'b01,
      ST_DIV = 2'b10
   } state_type;

endpackage

// File: rtl/rrsa_req_if.sv
interface rrsa_req_if;
   logic               valid;
   logic               ready;
   rrsa_pkg::pix_type  red_in;
   rrsa_pkg::pix_type  green_in;
   rrsa_pkg::pix_type  blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink (input valid, input red_in, input green_in, input blue_in,
                 output ready);
endinterface

// File: rtl/rrsa_rsp_if.sv
interface rrsa_rsp_if;
   logic               valid;
   logic               ready;
   rrsa_pkg::pix_type  red_avg;
   rrsa_pkg::pix_type  green_avg;
   rrsa_pkg::pix_type  blue_avg;

   modport source (output valid, output red_avg, output green_avg, output blue_avg,
                   input ready);
   modport sink (input valid, input red_avg, input green_avg, input blue_avg,
                 output ready);
endinterface

// File: rtl/rrsa_csr_if.sv
interface rrsa_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [rrsa_pkg::ROW_WIDTH_W-1:0]      row_width;

   modport source (output valid, output row_width, input ready);
   modport sink (input valid, input row_width, output ready);
endinterface

// File: rtl/rrsa_accum.sv
module rrsa_accum #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pix_take,
   input  rrsa_pkg::rgb_pix_type               pix,
   input  logic [rrsa_pkg::ROW_WIDTH_W-1:0]    row_width,
   output logic                                row_end,
   output rrsa_pkg::rgb_sum_type               sum_final,
   output rrsa_pkg::count_type                 count_final
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = rrsa_pkg::ROW_WIDTH_W;
   localparam int CMPW = (CW > RW) ? CW : RW;
   localparam int PW = CW + rrsa_pkg::STEP_RECIP_W;

   logic [CW-1:0]          col_ff, col_in;
   logic [CW-1:0]          nsc_ff, nsc_in;
   rrsa_pkg::rgb_sum_type  sum_ff, sum_in;
   rrsa_pkg::count_type    count_ff, count_in;

   logic [CMPW-1:0]        rw_ext;
   logic [CW-1:0]          eff_w;
   logic [PW-1:0]          step_prod;
   logic [CW-1:0]          step_raw;
   logic [CW-1:0]          step;
   logic [CW:0]            nsc_sum;
   logic                   hit;
   logic                   take;

   always_comb begin
      rw_ext = CMPW'(row_width);
      if (rw_ext == '0) begin
         eff_w = CW'(1);
      end else if (rw_ext > CMPW'(MAX_WIDTH)) begin
         eff_w = CW'(MAX_WIDTH);
      end else begin
         eff_w = CW'(rw_ext);
      end
      step_prod = PW'(eff_w) * PW'(rrsa_pkg::STEP_RECIP);
      step_raw = CW'(step_prod >> rrsa_pkg::STEP_SHIFT);
      step = (step_raw == '0) ? CW'(1) : step_raw;

      hit = (col_ff == nsc_ff);
      take = hit && (count_ff < rrsa_pkg::COUNT_MAX);
      row_end = (col_ff >= (eff_w - CW'(1)));

      sum_final = sum_ff;
      count_final = count_ff;
      if (take) begin
         sum_final.red = sum_ff.red + rrsa_pkg::SUM_W'(pix.red);
         sum_final.green = sum_ff.green + rrsa_pkg::SUM_W'(pix.green);
         sum_final.blue = sum_ff.blue + rrsa_pkg::SUM_W'(pix.blue);
         count_final = count_ff + rrsa_pkg::COUNT_W'(1);
      end

      nsc_sum = (CW + 1)'(nsc_ff) + (CW + 1)'(step);
      nsc_in = nsc_ff;
      if (hit) begin
         // sample column parks at the limit, which no column reaches
         nsc_in = (nsc_sum > (CW + 1)'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(nsc_sum);
      end

      col_in = col_ff;
      sum_in = sum_ff;
      count_in = count_ff;
      if (pix_take) begin
         if (row_end) begin
            col_in = '0;
            nsc_in = '0;
            sum_in = '0;
            count_in = '0;
         end else begin
            col_in = col_ff + CW'(1);
            sum_in = sum_final;
            count_in = count_final;
         end
      end else begin
         nsc_in = nsc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         nsc_ff <= '0;
         sum_ff <= '0;
         count_ff <= '0;
      end else begin
         col_ff <= col_in;
         nsc_ff <= nsc_in;
         sum_ff <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/rrsa_div.sv
module rrsa_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  rrsa_pkg::rgb_sum_type      dividend,
   input  rrsa_pkg::count_type        divisor,
   output rrsa_pkg::div_stat_type     stat,
   output rrsa_pkg::rgb_pix_type      quot
);

   localparam int WW = rrsa_pkg::DIV_STEPS;
   localparam int SW = rrsa_pkg::DIV_STEP_W;
   localparam int CB = rrsa_pkg::CHAN_BIT_W;
   localparam int DW = rrsa_pkg::COUNT_W;

   // the three dividends sit in one shift register; quotient bits replace them
   logic [WW-1:0]   work_ff, work_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   divisor_ff, divisor_in;
   logic [SW-1:0]   step_ff, step_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;

   logic [DW-1:0]   rem_base;
   logic [DW:0]     trial;
   logic            ge;

   always_comb begin
      rem_base = (step_ff[CB-1:0] == '0) ? '0 : rem_ff;
      trial = {rem_base, work_ff[WW-1]};
      ge = (trial >= {1'b0, divisor_ff});

      work_in = work_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;

      if (start) begin
         work_in = dividend;
         divisor_in = divisor;
         step_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         work_in = {work_ff[WW-2:0], ge};
         rem_in = ge ? DW'(trial - {1'b0, divisor_ff}) : DW'(trial);
         if (step_ff == SW'(WW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      work_ff <= work_in;
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot.red = work_ff[2 * rrsa_pkg::SUM_W +: rrsa_pkg::PIX_W];
   assign quot.green = work_ff[rrsa_pkg::SUM_W +: rrsa_pkg::PIX_W];
   assign quot.blue = work_ff[0 +: rrsa_pkg::PIX_W];

endmodule

// File: rtl/rgb_row_subsample_average_core.sv
// Row averager for an RGB24 raster stream. Every pixel accepted on req_bus adds to
// per-channel sums when its column is a sample column (column 0, then every
// row_width/10-th column, at least every one, at most 31 samples a row). Ordinary
// pixels are accepted back to back in the run state. The pixel that ends a row starts
// a shared bit-serial divider that yields one quotient bit a cycle over the three
// channels in turn. The input then stays held until the divider is done, and
// longer if the previous average has not yet been taken from rsp_bus. The averaged
// pixel waits in an output register so the next row streams in meanwhile. row_width
// is written through csr_bus; the user must write it only while the block is idle,
// which the block does not enforce. Zero acts as one, above MAX_WIDTH as MAX_WIDTH.
module rgb_row_subsample_average_core #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic          clock,
   input  logic          reset,
   rrsa_req_if.sink      req_bus,
   rrsa_rsp_if.source    rsp_bus,
   rrsa_csr_if.sink      csr_bus
);

   rrsa_pkg::state_type                state_ff, state_in;
   logic [rrsa_pkg::ROW_WIDTH_W-1:0]   row_width_ff, row_width_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   rrsa_pkg::rgb_pix_type              rsp_data_ff, rsp_data_in;
   logic                               zero_cnt_ff, zero_cnt_in;

   logic                               pix_take;
   logic                               row_end;
   logic                               div_start;
   rrsa_pkg::rgb_pix_type              pix;
   rrsa_pkg::rgb_sum_type              sum_final;
   rrsa_pkg::count_type                count_final;
   rrsa_pkg::div_stat_type             div_stat;
   rrsa_pkg::rgb_pix_type              quot;
   logic                               out_free;

   assign pix.red = req_bus.red_in;
   assign pix.green = req_bus.green_in;
   assign pix.blue = req_bus.blue_in;

   assign req_bus.ready = (state_ff == rrsa_pkg::ST_RUN);
   assign csr_bus.ready = 1'b1;
   assign pix_take = req_bus.valid && req_bus.ready;
   assign div_start = pix_take && row_end;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   rrsa_accum #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .pix_take    (pix_take),
      .pix         (pix),
      .row_width   (row_width_ff),
      .row_end     (row_end),
      .sum_final   (sum_final),
      .count_final (count_final)
   );

   rrsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_final),
      .divisor  (count_final),
      .stat     (div_stat),
      .quot     (quot)
   );

   always_comb begin
      state_in = state_ff;
      row_width_in = row_width_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      zero_cnt_in = zero_cnt_ff;

      if (csr_bus.valid) begin
         row_width_in = csr_bus.row_width;
      end
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         rrsa_pkg::ST_RUN: begin
            if (div_start) begin
               zero_cnt_in = (count_final == '0);
               state_in = rrsa_pkg::ST_DIV;
            end
         end
         rrsa_pkg::ST_DIV: begin
            if (div_stat.done && out_free) begin
               // an empty row reports all zeros
               rsp_data_in = zero_cnt_ff ? '0 : quot;
               rsp_valid_in = 1'b1;
               state_in = rrsa_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = rrsa_pkg::ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrsa_pkg::ST_RUN;
         row_width_ff <= rrsa_pkg::ROW_WIDTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_width_ff <= row_width_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      zero_cnt_ff <= zero_cnt_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.red_avg = rsp_data_ff.red;
   assign rsp_bus.green_avg = rsp_data_ff.green;
   assign rsp_bus.blue_avg = rsp_data_ff.blue;

`ifndef SYNTHESIS
   a_no_pixel_while_dividing: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && div_stat.busy))
      else $error("input ready while divider busy");

   a_row_end_starts_divide: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && row_end) |=> (div_stat.busy && !req_bus.ready))
      else $error("row end did not start divider");

   a_result_after_divide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(div_stat.done))
      else $error("result transaction without finished divide");
`endif

endmodule
